[sv/dpm_pkg.sv]
package dpm_pkg;

	localparam int FRAC_DIGITS = 3;

	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 63;
	localparam int TDATA_W = ((VALUE_W + 7) / 8) * 8;

	function automatic longint unsigned pow10(input int n);
		longint unsigned v;
		v = 64'd1;
		for (int i = 0; i < n; i++) begin
			v = v * 64'd10;
		end
		return v;
	endfunction

	localparam longint unsigned MAX_VALUE = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam longint unsigned INT_LIMIT = MAX_VALUE / 64'd10000;
	localparam longint unsigned SCALE     = pow10(FRAC_DIGITS);

	localparam int INT_W   = $clog2(INT_LIMIT * 10 + 10);
	localparam int FRAC_W  = $clog2(SCALE);
	localparam int CNT_W   = $clog2(FRAC_DIGITS + 1);
	localparam int SCALE_W = $clog2(SCALE + 1);
	localparam int PROD_W  = INT_W + SCALE_W;
	localparam int SUM_W   = PROD_W + 1;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	// Field state at the closing item, handed from the parser to the scaler
	typedef struct packed {
		logic              ok;
		logic [INT_W-1:0]  int_val;
		logic [FRAC_W-1:0] frac_val;
		logic [CNT_W-1:0]  frac_cnt;
	} snap_t;

endpackage

[sv/decimal_price_to_milli_unit.sv]
// Decimal price parser. Feed one character of a text field per request on the
// slave side; the request with tlast closes the field and yields exactly one
// result request on the master side, carrying the price in thousandths and a
// valid flag. Blanks (space, tab, carriage return) around the body are skipped,
// one leading plus is allowed, at least one integer digit is needed, and after
// an optional dot only the first three fraction digits count (the rest are
// truncated). Malformed text, an integer part that grows too long, or a value
// above 2^63-1 gives parse_ok 0 and a zero value. A request with tuser low and
// tlast low is a no-op; tuser low with tlast high closes the field without
// adding a character. One request is taken per clock while tready is high: the
// parse state is updated by a single multiply-by-ten accumulate per character,
// and the result of a closed field passes through the input register, the
// parse stage and the scaling stage into the output register. While the
// master side stalls, up to two finished fields wait in the snapshot and output
// registers; a third closing request then waits in the input register and only
// then does tready drop.
module decimal_price_to_milli_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [dpm_pkg::CHAR_W-1:0]  s_axis_tdata,  // [7:0] char_byte
	input  logic                        s_axis_tuser,  // [0] has_byte
	input  logic                        s_axis_tlast,  // end_of_field
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [dpm_pkg::TDATA_W-1:0] m_axis_tdata,  // [62:0] milli_value, [63] zero
	output logic                        m_axis_tuser   // [0] parse_ok
);
	import dpm_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              has_s1;
	logic              eof_s1;
	logic              go_s1;
	logic              parse_free;
	logic              snap_valid;
	logic              snap_take;
	snap_t             snap;

	// Advance a plain character at once; hold a closing one until the
	// snapshot slot is free.
	assign go_s1         = valid_s1 && (!eof_s1 || parse_free);
	assign s_axis_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			has_s1  <= s_axis_tuser;
			eof_s1  <= s_axis_tlast;
		end
	end

	dpm_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go_s1),
		.char_byte    (char_s1),
		.has_byte     (has_s1),
		.end_of_field (eof_s1),
		.snap_take    (snap_take),
		.free         (parse_free),
		.snap_valid   (snap_valid),
		.snap         (snap)
	);

	dpm_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (snap_valid),
		.in_ready      (snap_take),
		.snap          (snap),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// A closing character must produce a snapshot on the next edge.
	a_close_snaps: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && eof_s1) |=> snap_valid)
		else $error("closed field produced no snapshot");

	// A rejected field reports a zero value.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("rejected field carries a non-zero value");

	// Result never exceeds 63 bits.
	a_top_bit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[TDATA_W-1])
		else $error("result overflowed into the pad bit");

	// A plain character is never stalled in the input register.
	a_char_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !eof_s1) |-> s_axis_tready)
		else $error("plain character stalled");

endmodule

[sv/dpm_parse.sv]
module dpm_parse (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [dpm_pkg::CHAR_W-1:0] char_byte,
	input  logic                       has_byte,
	input  logic                       end_of_field,
	input  logic                       snap_take,
	output logic                       free,
	output logic                       snap_valid,
	output dpm_pkg::snap_t             snap
);
	import dpm_pkg::*;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_INT,
		PH_FRAC,
		PH_TRAIL
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [INT_W-1:0]   int_q, int_n;
	logic [FRAC_W-1:0]  frac_q, frac_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic               saw_q, saw_n;
	logic               err_q, err_n;
	logic               snap_valid_q;
	snap_t              snap_s2;

	logic               is_digit;
	logic               is_blank;
	logic [CHAR_W-1:0]  digit;

	assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
	assign is_blank = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
		(char_byte == CH_CR);
	assign digit    = char_byte - CH_ZERO;

	always_comb begin
		logic take_int;
		take_int = 1'b0;
		phase_n  = phase_q;
		int_n    = int_q;
		frac_n   = frac_q;
		cnt_n    = cnt_q;
		saw_n    = saw_q;
		err_n    = err_q;
		if (has_byte && !err_q) begin
			case (phase_q)
				PH_LEAD: begin
					if (char_byte == CH_PLUS) begin
						phase_n = PH_INT;
					end else if (is_digit) begin
						phase_n  = PH_INT;
						take_int = 1'b1;
					end else if (!is_blank) begin
						err_n = 1'b1;
					end
				end
				PH_INT: begin
					if (is_digit) begin
						take_int = 1'b1;
					end else if (char_byte == CH_DOT && saw_q) begin
						phase_n = PH_FRAC;
					end else if (is_blank) begin
						phase_n = PH_TRAIL;
					end else begin
						err_n = 1'b1;
					end
				end
				PH_FRAC: begin
					if (is_digit) begin
						if (cnt_q < CNT_W'(FRAC_DIGITS)) begin
							frac_n = (frac_q << 3) + (frac_q << 1) + FRAC_W'(digit);
							cnt_n  = cnt_q + 1'b1;
						end
					end else if (is_blank) begin
						phase_n = PH_TRAIL;
					end else begin
						err_n = 1'b1;
					end
				end
				PH_TRAIL: begin
					if (!is_blank) begin
						err_n = 1'b1;
					end
				end
				default: begin
					err_n = 1'b1;
				end
			endcase
			// integer digit: refuse once the accumulator is past the limit
			if (take_int) begin
				if (int_q > INT_W'(INT_LIMIT)) begin
					err_n = 1'b1;
				end else begin
					int_n = (int_q << 3) + (int_q << 1) + INT_W'(digit);
					saw_n = 1'b1;
				end
			end
		end
	end

	assign free = !snap_valid_q || snap_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LEAD;
			int_q        <= '0;
			frac_q       <= '0;
			cnt_q        <= '0;
			saw_q        <= 1'b0;
			err_q        <= 1'b0;
			snap_valid_q <= 1'b0;
		end else begin
			// a new snapshot wins over the one being taken
			snap_valid_q <= (go && end_of_field) || (snap_valid_q && !snap_take);
			if (go) begin
				if (end_of_field) begin
					// close the field and return to the idle state
					phase_q      <= PH_LEAD;
					int_q        <= '0;
					frac_q       <= '0;
					cnt_q        <= '0;
					saw_q        <= 1'b0;
					err_q        <= 1'b0;
				end else begin
					phase_q <= phase_n;
					int_q   <= int_n;
					frac_q  <= frac_n;
					cnt_q   <= cnt_n;
					saw_q   <= saw_n;
					err_q   <= err_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && end_of_field) begin
			snap_s2.ok       <= !err_n && saw_n;
			snap_s2.int_val  <= int_n;
			snap_s2.frac_val <= frac_n;
			snap_s2.frac_cnt <= cnt_n;
		end
	end

	assign snap_valid = snap_valid_q;
	assign snap       = snap_s2;

endmodule

[sv/dpm_scale.sv]
module dpm_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  dpm_pkg::snap_t              snap,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [dpm_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                        m_axis_tuser
);
	import dpm_pkg::*;

	logic [SCALE_W-1:0] frac_scale;
	logic [FRAC_W-1:0]  frac_full;
	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   sum;
	logic               ok;
	logic               valid_q;
	logic [VALUE_W-1:0] value_q;
	logic               ok_q;

	// pad missing fraction digits with zeros
	always_comb begin
		frac_scale = '0;
		for (int k = 0; k <= FRAC_DIGITS; k++) begin
			if (snap.frac_cnt == CNT_W'(k)) begin
				frac_scale = SCALE_W'(pow10(FRAC_DIGITS - k));
			end
		end
	end

	assign frac_full = FRAC_W'(snap.frac_val * frac_scale);
	assign prod      = PROD_W'(snap.int_val) * PROD_W'(SCALE);
	assign sum       = SUM_W'(prod) + SUM_W'(frac_full);
	assign ok        = snap.ok && (sum <= SUM_W'(MAX_VALUE));

	assign in_ready = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			value_q <= ok ? sum[VALUE_W-1:0] : '0;
			ok_q    <= ok;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = TDATA_W'(value_q);
	assign m_axis_tuser  = ok_q;

endmodule
